FILE: design/fpcv_pkg.sv
`default_nettype none

package fpcv_pkg;

  // direction selector
  typedef enum logic {
    OP_NARROW = 1'b0,
    OP_WIDEN  = 1'b1
  } op_t;

  // operand class carried down the pipe
  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_INF  = 2'd1,
    CLS_NAN  = 2'd2,
    CLS_NUM  = 2'd3
  } cls_t;

  localparam logic [14:0] H_INF      = 15'h7C00;
  localparam logic [14:0] H_QNAN     = 15'h7E00;
  localparam logic [23:0] LSB_ADD    = 24'h002000;
  localparam int          RND_POS    = 12;
  localparam logic [7:0]  F_EXP_ALL  = 8'hFF;
  localparam logic [7:0]  SUB_EXP_BASE = 8'(127 - 15 + 1);
  localparam logic [7:0]  EXP_BIAS_D = 8'(127 - 15);

  // one pipeline stage worth of item state
  typedef struct packed {
    logic        valid;
    op_t         op;
    logic        sign;
    cls_t        cls;
    logic [7:0]  expo;
    logic [23:0] mant;
    logic [3:0]  shamt;
  } stage_t;

endpackage

`default_nettype wire

FILE: design/fpcv_decode.sv
`default_nettype none

module fpcv_decode (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_take,
  input  wire logic            in_op,
  input  wire logic [31:0]     in_value,
  output fpcv_pkg::stage_t     s1_o
);

  localparam logic [7:0] SUB_EXP_BASE_W = fpcv_pkg::SUB_EXP_BASE;

  fpcv_pkg::stage_t s1_r;
  fpcv_pkg::stage_t s1_nxt;

  logic [7:0]  f_exp;
  logic [22:0] f_man;
  logic [4:0]  h_exp;
  logic [9:0]  h_man;
  logic [3:0]  lz;
  logic [7:0]  sub_sh;

  // leading-zero count of the binary16 mantissa, as left shift to bit 10
  always_comb begin
    lz = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (h_man[i]) begin
        lz = 4'(10 - i);
      end
    end
  end

  always_comb begin
    f_exp  = in_value[30:23];
    f_man  = in_value[22:0];
    h_exp  = in_value[14:10];
    h_man  = in_value[9:0];
    sub_sh = SUB_EXP_BASE_W - f_exp;

    s1_nxt       = s1_r;
    s1_nxt.valid = in_take;
    s1_nxt.op    = fpcv_pkg::op_t'(in_op);
    s1_nxt.shamt = 4'd0;
    s1_nxt.expo  = 8'd0;
    s1_nxt.mant  = 24'd0;
    s1_nxt.cls   = fpcv_pkg::CLS_NUM;

    if (fpcv_pkg::op_t'(in_op) == fpcv_pkg::OP_NARROW) begin
      s1_nxt.sign = in_value[31];
      if (f_exp == fpcv_pkg::F_EXP_ALL) begin
        s1_nxt.cls = (f_man == 23'd0) ? fpcv_pkg::CLS_INF : fpcv_pkg::CLS_NAN;
      end else if (f_exp >= 8'd143) begin
        s1_nxt.cls = fpcv_pkg::CLS_INF;
      end else if (f_exp <= 8'd101) begin
        s1_nxt.cls = fpcv_pkg::CLS_ZERO;
      end else if (f_exp <= 8'd112) begin
        // subnormal result: hidden bit joins, shift right 1..11
        s1_nxt.mant  = {1'b1, f_man};
        s1_nxt.shamt = sub_sh[3:0];
      end else begin
        s1_nxt.expo = f_exp - fpcv_pkg::EXP_BIAS_D;
        s1_nxt.mant = {1'b0, f_man};
      end
    end else begin
      s1_nxt.sign = in_value[15];
      s1_nxt.mant = {1'b0, h_man, 13'd0};
      if (h_exp == 5'd0) begin
        if (h_man == 10'd0) begin
          s1_nxt.cls = fpcv_pkg::CLS_ZERO;
        end else begin
          s1_nxt.expo  = fpcv_pkg::SUB_EXP_BASE - {4'd0, lz};
          s1_nxt.shamt = lz;
        end
      end else if (h_exp == 5'h1F) begin
        // inf and nan keep payload, all-ones exponent
        s1_nxt.expo = fpcv_pkg::F_EXP_ALL;
      end else begin
        s1_nxt.expo = {3'd0, h_exp} + fpcv_pkg::EXP_BIAS_D;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else begin
      s1_r.valid <= s1_nxt.valid;
    end
    s1_r.op    <= s1_nxt.op;
    s1_r.sign  <= s1_nxt.sign;
    s1_r.cls   <= s1_nxt.cls;
    s1_r.expo  <= s1_nxt.expo;
    s1_r.mant  <= s1_nxt.mant;
    s1_r.shamt <= s1_nxt.shamt;
  end

  assign s1_o = s1_r;

endmodule

`default_nettype wire

FILE: design/fpcv_align.sv
`default_nettype none

module fpcv_align (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  fpcv_pkg::stage_t     s1_i,
  output fpcv_pkg::stage_t     s2_o
);

  fpcv_pkg::stage_t s2_r;
  fpcv_pkg::stage_t s2_nxt;

  logic [23:0] hm;
  logic [23:0] wm;

  always_comb begin
    hm = s1_i.mant >> s1_i.shamt;
    wm = s1_i.mant << s1_i.shamt;

    s2_nxt       = s1_i;
    s2_nxt.shamt = 4'd0;
    if (s1_i.op == fpcv_pkg::OP_NARROW) begin
      // round to nearest, ties away from zero
      if (hm[fpcv_pkg::RND_POS]) begin
        s2_nxt.mant = hm + fpcv_pkg::LSB_ADD;
      end else begin
        s2_nxt.mant = hm;
      end
    end else begin
      // renormalized: hidden bit drops out above bit 22
      s2_nxt.mant = {1'b0, wm[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else begin
      s2_r.valid <= s2_nxt.valid;
    end
    s2_r.op    <= s2_nxt.op;
    s2_r.sign  <= s2_nxt.sign;
    s2_r.cls   <= s2_nxt.cls;
    s2_r.expo  <= s2_nxt.expo;
    s2_r.mant  <= s2_nxt.mant;
    s2_r.shamt <= s2_nxt.shamt;
  end

  assign s2_o = s2_r;

endmodule

`default_nettype wire

FILE: design/fpcv_pack.sv
`default_nettype none

module fpcv_pack (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  fpcv_pkg::stage_t     s2_i,
  output logic                 out_valid,
  output logic [31:0]          out_result
);

  logic        valid_r;
  logic [31:0] result_r;
  logic [31:0] result_nxt;
  logic [14:0] h_mag;

  always_comb begin
    // a mantissa carry rolls into the exponent, up to infinity
    h_mag = {s2_i.expo[4:0], 10'd0} + {4'd0, s2_i.mant[23:13]};

    if (s2_i.op == fpcv_pkg::OP_NARROW) begin
      case (s2_i.cls)
        fpcv_pkg::CLS_ZERO: result_nxt = {16'd0, s2_i.sign, 15'd0};
        fpcv_pkg::CLS_INF:  result_nxt = {16'd0, s2_i.sign, fpcv_pkg::H_INF};
        fpcv_pkg::CLS_NAN:  result_nxt = {16'd0, s2_i.sign, fpcv_pkg::H_QNAN};
        default:            result_nxt = {16'd0, s2_i.sign, h_mag};
      endcase
    end else begin
      case (s2_i.cls)
        fpcv_pkg::CLS_ZERO: result_nxt = {s2_i.sign, 31'd0};
        default:            result_nxt = {s2_i.sign, s2_i.expo, s2_i.mant[22:0]};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= s2_i.valid;
    end
    result_r <= result_nxt;
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

`default_nettype wire

FILE: design/fp32_fp16_converter_unit.sv
// binary32 <-> binary16 converter, three register stages: decode, align/round, pack
// each accepted item passes the decode, align and pack registers before out_valid
// throughput: one item per cycle, set by the fully pipelined datapath; busy stays low
// the result side cannot stall, so no stage ever holds an item back
// reset (rst_n low, synchronous) clears the stage valid bits; payload is not reset
`default_nettype none

module fp32_fp16_converter_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input item channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_op,
  input  wire logic [31:0] in_value,
  // result channel
  output logic             out_valid,
  output logic [31:0]      out_result
);

  fpcv_pkg::stage_t s1;
  fpcv_pkg::stage_t s2;
  logic             in_take;

  // pipeline never backs up, so the block is always ready
  assign busy    = 1'b0;
  assign in_take = start & ~busy;

  // stage 1: field split, classification, shift amount and exponent
  fpcv_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_take  (in_take),
    .in_op    (in_op),
    .in_value (in_value),
    .s1_o     (s1)
  );

  // stage 2: subnormal right shift plus rounding, or widening renormalize
  fpcv_align u_align (
    .clk   (clk),
    .rst_n (rst_n),
    .s1_i  (s1),
    .s2_o  (s2)
  );

  // stage 3: special values and final packing into the output register
  fpcv_pack u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .s2_i       (s2),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule

`default_nettype wire
